[rtl/sstf_pkg.sv]
// sstf_pkg: shared types and codes of the shortest-seek-first request queue
// no dependencies; imported by sstf_seek, sstf_ctrl and sstf_request_queue
package sstf_pkg;

    localparam int ID_W    = 8;
    localparam int TRACK_W = 16;
    localparam int CAP_W   = 4;
    localparam int OCC_W   = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef enum logic [1:0] {
        STAT_PUSHED = 2'd0,
        STAT_SERVED = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_EMPTY  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [TRACK_W-1:0] track;
    } entry_t;

    typedef struct packed {
        logic en;
        logic first;
    } seek_ctl_t;

endpackage

[rtl/sstf_request_queue.sv]
// sstf_request_queue: top level of the shortest-seek-first request queue
// depends on sstf_pkg and sstf_ctrl; holds the capacity register
//
//  channel   signals                                          handshake
//  request   opcode, req_id, track                            start & !busy
//  result    status, served_id, served_track, occupancy       done, one cycle
//  config    cfg_data (queue capacity)                        cfg_valid & cfg_ready
//
// push, refused push and empty pop: result in the cycle after the transfer
// pop: one memory read per entry in the scan, result registered when the scan ends,
// then busy in the shift state to close the gap, skipped when the last entry is served
// no memory clearing after reset; the result side cannot stall
module sstf_request_queue #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          opcode,
    input  logic [sstf_pkg::ID_W-1:0]     req_id,
    input  logic [sstf_pkg::TRACK_W-1:0]  track,
    output logic                          done,
    output logic [1:0]                    status,
    output logic [sstf_pkg::ID_W-1:0]     served_id,
    output logic [sstf_pkg::TRACK_W-1:0]  served_track,
    output logic [sstf_pkg::OCC_W-1:0]    occupancy,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sstf_pkg::CAP_W-1:0]    cfg_data
);
    import sstf_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    status_t          status_q;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            capacity_reg <= cfg_data;
        end
    end

    sstf_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .opcode       (opcode),
        .req_id       (req_id),
        .track        (track),
        .capacity     (capacity_reg),
        .busy         (busy),
        .done         (done),
        .status       (status_q),
        .served_id    (served_id),
        .served_track (served_track),
        .occupancy    (occupancy)
    );

    assign status = status_q;

endmodule

[rtl/sstf_seek.sv]
// sstf_seek: nearest-track tracker, compares one entry per cycle against the head while enabled
// depends on sstf_pkg
module sstf_seek #(
    parameter int AW = 3
) (
    input  logic                          clk,
    input  sstf_pkg::seek_ctl_t           ctl,
    input  logic [sstf_pkg::TRACK_W-1:0]  head_track,
    input  sstf_pkg::entry_t              entry,
    input  logic [AW-1:0]                 index,
    output sstf_pkg::entry_t              pick_entry,
    output logic [AW-1:0]                 pick_index
);
    import sstf_pkg::*;

    entry_t              best_entry_reg;
    logic [TRACK_W-1:0]  best_gap_reg;
    logic [AW-1:0]       best_index_reg;
    logic [TRACK_W-1:0]  gap;
    logic                take;

    always_comb
    begin
        if (entry.track >= head_track)
        begin
            gap = entry.track - head_track;
        end
        else
        begin
            gap = head_track - entry.track;
        end
        // strict compare keeps the oldest on a tie
        take = ctl.en && (ctl.first || (gap < best_gap_reg));
    end

    assign pick_entry = take ? entry : best_entry_reg;
    assign pick_index = take ? index : best_index_reg;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_entry_reg <= entry;
            best_gap_reg   <= gap;
            best_index_reg <= index;
        end
    end

endmodule

[rtl/sstf_ctrl.sv]
// sstf_ctrl: request memory, scan and compaction sequencer, result registers
// depends on sstf_pkg and sstf_seek
module sstf_ctrl #(
    parameter int QUEUE_DEPTH = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          opcode,
    input  logic [sstf_pkg::ID_W-1:0]     req_id,
    input  logic [sstf_pkg::TRACK_W-1:0]  track,
    input  logic [sstf_pkg::CAP_W-1:0]    capacity,
    output logic                          busy,
    output logic                          done,
    output sstf_pkg::status_t             status,
    output logic [sstf_pkg::ID_W-1:0]     served_id,
    output logic [sstf_pkg::TRACK_W-1:0]  served_track,
    output logic [sstf_pkg::OCC_W-1:0]    occupancy
);
    import sstf_pkg::*;

    localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW   = $clog2(QUEUE_DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

    entry_t entry_mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    state_t              state_reg, state_next;
    logic [CW-1:0]       held_reg, held_next;
    logic [TRACK_W-1:0]  head_track_reg, head_track_next;
    logic [CW-1:0]       rd_idx_reg, rd_idx_next;
    logic [AW-1:0]       chk_idx_reg, chk_idx_next;
    logic [CW-1:0]       src_reg, src_next;
    logic [AW-1:0]       dst_reg, dst_next;
    logic                wv_reg, wv_next;

    logic                done_reg, done_next;
    status_t             status_reg, status_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [TRACK_W-1:0]  trk_reg, trk_next;
    logic [OCC_W-1:0]    occ_reg, occ_next;

    logic                rd_en, wr_en;
    logic [AW-1:0]       rd_addr, wr_addr;
    entry_t              wr_data;

    seek_ctl_t           seek_ctl;
    entry_t              pick_entry;
    logic [AW-1:0]       pick_index;

    logic                accept, full, scan_last, scan_rd, shift_rd, shift_needed;

    assign accept       = start && (state_reg == ST_IDLE);
    assign full         = (CMPW'(held_reg) >= CMPW'(capacity))
                          || (held_reg >= CW'(QUEUE_DEPTH));
    assign scan_last    = (CW'(chk_idx_reg) + CW'(1)) == held_reg;
    assign scan_rd      = rd_idx_reg < held_reg;
    assign shift_rd     = src_reg <= held_reg;
    assign shift_needed = (CW'(pick_index) + CW'(1)) != held_reg;

    sstf_seek #(
        .AW (AW)
    ) u_seek (
        .clk        (clk),
        .ctl        (seek_ctl),
        .head_track (head_track_reg),
        .entry      (rd_data_reg),
        .index      (chk_idx_reg),
        .pick_entry (pick_entry),
        .pick_index (pick_index)
    );

    // request memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (opcode == OP_POP) && (held_reg != '0))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = shift_needed ? ST_SHIFT : ST_IDLE;
                end
            end
            ST_SHIFT:
            begin
                if (!shift_rd)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        held_next       = held_reg;
        head_track_next = head_track_reg;
        rd_idx_next     = rd_idx_reg;
        chk_idx_next    = chk_idx_reg;
        src_next        = src_reg;
        dst_next        = dst_reg;
        wv_next         = wv_reg;
        done_next       = 1'b0;
        status_next     = status_reg;
        id_next         = id_reg;
        trk_next        = trk_reg;
        occ_next        = occ_reg;
        rd_en           = 1'b0;
        rd_addr         = '0;
        wr_en           = 1'b0;
        wr_addr         = '0;
        wr_data         = rd_data_reg;
        seek_ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_PUSH)
                    begin
                        done_next = 1'b1;
                        id_next   = '0;
                        trk_next  = '0;
                        if (full)
                        begin
                            status_next = STAT_FULL;
                            occ_next    = OCC_W'(held_reg);
                        end
                        else
                        begin
                            wr_en         = 1'b1;
                            wr_addr       = held_reg[AW-1:0];
                            wr_data.id    = req_id;
                            wr_data.track = track;
                            held_next     = held_reg + CW'(1);
                            status_next   = STAT_PUSHED;
                            occ_next      = OCC_W'(held_reg + CW'(1));
                        end
                    end
                    else if (held_reg == '0)
                    begin
                        done_next   = 1'b1;
                        status_next = STAT_EMPTY;
                        id_next     = '0;
                        trk_next    = '0;
                        occ_next    = '0;
                    end
                    else
                    begin
                        rd_en        = 1'b1;
                        rd_addr      = '0;
                        rd_idx_next  = CW'(1);
                        chk_idx_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                seek_ctl.en    = 1'b1;
                seek_ctl.first = (chk_idx_reg == '0);
                chk_idx_next   = chk_idx_reg + AW'(1);
                if (scan_rd)
                begin
                    rd_en       = 1'b1;
                    rd_addr     = rd_idx_reg[AW-1:0];
                    rd_idx_next = rd_idx_reg + CW'(1);
                end
                if (scan_last)
                begin
                    done_next       = 1'b1;
                    status_next     = STAT_SERVED;
                    id_next         = pick_entry.id;
                    trk_next        = pick_entry.track;
                    head_track_next = pick_entry.track;
                    held_next       = held_reg - CW'(1);
                    occ_next        = OCC_W'(held_reg - CW'(1));
                    dst_next        = pick_index;
                    src_next        = CW'(pick_index) + CW'(1);
                    wv_next         = 1'b0;
                end
            end
            ST_SHIFT:
            begin
                // move the entries behind the served one down by one place
                if (wv_reg)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = dst_reg;
                    wr_data  = rd_data_reg;
                    dst_next = dst_reg + AW'(1);
                end
                if (shift_rd)
                begin
                    rd_en    = 1'b1;
                    rd_addr  = src_reg[AW-1:0];
                    src_next = src_reg + CW'(1);
                    wv_next  = 1'b1;
                end
                else
                begin
                    wv_next = 1'b0;
                end
            end
            default:
            begin
                wv_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            held_reg       <= '0;
            head_track_reg <= '0;
            wv_reg         <= 1'b0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            held_reg       <= held_next;
            head_track_reg <= head_track_next;
            wv_reg         <= wv_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_idx_reg  <= rd_idx_next;
        chk_idx_reg <= chk_idx_next;
        src_reg     <= src_next;
        dst_reg     <= dst_next;
        status_reg  <= status_next;
        id_reg      <= id_next;
        trk_reg     <= trk_next;
        occ_reg     <= occ_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign served_id    = id_reg;
    assign served_track = trk_reg;
    assign occupancy    = occ_reg;

`ifndef NO_ASSERTIONS
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= CW'(QUEUE_DEPTH))
        else $error("held count above queue depth");

    a_shift_order: assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && rd_en) |-> (wr_addr < rd_addr))
        else $error("compaction write overtakes its read");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_POP) && (held_reg == '0))
        |=> (done_reg && (status_reg == STAT_EMPTY)))
        else $error("pop of empty queue not reported");

    a_served_head: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (status_reg == STAT_SERVED)) |-> (head_track_reg == trk_reg))
        else $error("head position differs from served track");

    a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (opcode == OP_PUSH) && !full)
        |=> (held_reg == ($past(held_reg) + CW'(1))))
        else $error("push transfer did not grow the queue");
`endif

endmodule
